// File: rtl/core/skf_pkg.sv
// Shared types and constants of the scalar Kalman smoother.
package skf_pkg;

    localparam int unsigned SAMPLE_W = 17;
    localparam int unsigned EST_W    = 33;
    localparam int unsigned LAST_W   = 34;
    localparam int unsigned GAIN_W   = 17;
    localparam int unsigned ERR_W    = 32;
    localparam int unsigned NOISE_W  = 16;
    localparam int unsigned MUL_A_W  = 34;
    localparam int unsigned MUL_B_W  = 17;
    localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned DIV_D_W  = 33;
    localparam int unsigned DIV_R_W  = DIV_D_W + 1;
    localparam int unsigned DIV_CNT_W = 5;
    localparam int unsigned ACC_W    = 52;
    localparam int unsigned ADDR_W   = 4;

    localparam logic [ERR_W-1:0]   ERR_RESET   = 32'd131072;
    localparam logic [NOISE_W-1:0] NOISE_RESET = 16'd655;
    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'h10000;
    localparam logic [ACC_W-1:0]   HALF_Q16    = 52'd32768;

    typedef enum logic [1:0] {
        REG_MEAS_ERR   = 2'd0,
        REG_INIT_ERR   = 2'd1,
        REG_PROC_NOISE = 2'd2
    } t_reg_addr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_STEP,
        S_MUL_ERR,
        S_MUL_NOISE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [ERR_W-1:0]   meas_err;
        logic [NOISE_W-1:0] proc_noise;
        logic               err_load;
        logic [ERR_W-1:0]   err_load_value;
    } t_cfg;

endpackage

// File: rtl/core/skf_regs.sv
// APB register file of the scalar Kalman smoother.
module skf_regs
    import skf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [ERR_W-1:0]   r_meas_err;
    logic [ERR_W-1:0]   r_init_err;
    logic [NOISE_W-1:0] r_proc_noise;
    logic               w_wr;
    t_reg_addr          w_addr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_addr = t_reg_addr'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_err   <= ERR_RESET;
            r_init_err   <= ERR_RESET;
            r_proc_noise <= NOISE_RESET;
        end else if (w_wr) begin
            case (w_addr)
                REG_MEAS_ERR:   r_meas_err   <= pwdata;
                REG_INIT_ERR:   r_init_err   <= pwdata;
                REG_PROC_NOISE: r_proc_noise <= pwdata[NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_addr)
            REG_MEAS_ERR:   prdata = r_meas_err;
            REG_INIT_ERR:   prdata = r_init_err;
            REG_PROC_NOISE: prdata = {16'd0, r_proc_noise};
            default:        prdata = 32'd0;
        endcase
    end

    // error state reloads together with the initial-error register
    assign o_cfg.meas_err       = r_meas_err;
    assign o_cfg.proc_noise     = r_proc_noise;
    assign o_cfg.err_load       = w_wr && (w_addr == REG_INIT_ERR);
    assign o_cfg.err_load_value = pwdata;

endmodule

// File: rtl/core/skf_div.sv
// Restoring divider, one quotient bit per cycle.
module skf_div
    import skf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_R_W-1:0] i_rem_init,
    input  logic [GAIN_W-1:0]  i_bits,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [GAIN_W-1:0]  o_quot
);

    logic [DIV_R_W-1:0]   r_rem;
    logic [GAIN_W-1:0]    r_bits;
    logic [GAIN_W-1:0]    r_quot;
    logic [DIV_D_W-1:0]   r_divisor;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_R_W-1:0]   w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem[DIV_R_W-2:0], r_bits[GAIN_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_rem_init;
            r_bits    <= i_bits;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_fit ? (w_trial - {1'b0, r_divisor}) : w_trial;
            r_bits <= {r_bits[GAIN_W-2:0], 1'b0};
            r_quot <= {r_quot[GAIN_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/core/skf_mul.sv
// Shared unsigned multiplier with registered product.
module skf_mul
    import skf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= {{MUL_B_W{1'b0}}, i_a} * {{MUL_A_W{1'b0}}, i_b};
        end
    end

    assign o_p = r_p;

endmodule

// File: rtl/core/scalar_kalman_smoother_unit.sv
// Top level of the scalar Kalman smoother: sequencer, state and stream ports.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------------
//  s_*      | in        | s_tvalid / s_tready       | s_tdata: measurement [16:0]
//  m_*      | out       | m_tvalid / m_tready       | m_tdata: estimate [32:0], gain [49:33]
//  APB      | in        | psel, penable, pready=1   | paddr, pwdata (write), prdata (read)
//
// A word goes from acceptance to the result register through these steps: the divider for the
// gain, one to latch it, three issues of the single 34x17 multiplier (step, error decay, noise
// term) and one to sum the error terms and load the result.
// s_tready is high only while idle, so a new word is taken only after the last one has been loaded.
// A result that is not taken holds the sequencer in its final step until m_tready.
// Reset (synchronous, active low) restores the registers, zeroes the estimate, error 2.0.
module scalar_kalman_smoother_unit
    import skf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // [16:0] measurement, [23:17] zero
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,   // [32:0] estimate, [49:33] gain, [55:50] zero
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_state               r_state;
    t_state               n_state;
    t_cfg                 w_cfg;

    logic [LAST_W-1:0]    r_last;
    logic [ERR_W-1:0]     r_err;
    logic [LAST_W-1:0]    r_mag;
    logic                 r_neg;
    logic                 r_sum_zero;
    logic [GAIN_W-1:0]    r_gain;
    logic [LAST_W-1:0]    r_step;
    logic [ACC_W-1:0]     r_acc;
    logic                 r_m_tvalid;
    logic [EST_W-1:0]     r_est_out;
    logic [GAIN_W-1:0]    r_gain_out;

    logic                 w_accept;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [GAIN_W-1:0]    w_quot;
    logic [DIV_D_W-1:0]   w_sum;
    logic [LAST_W:0]      w_target;
    logic [LAST_W:0]      w_diff;
    logic [LAST_W:0]      w_diff_neg;
    logic                 w_mul_en;
    logic [MUL_A_W-1:0]   w_mul_a;
    logic [MUL_B_W-1:0]   w_mul_b;
    logic [MUL_P_W-1:0]   w_prod;
    logic [ACC_W-1:0]     w_step_sum;
    logic [ACC_W-1:0]     w_acc_total;
    logic [ERR_W-1:0]     w_err_next;
    logic [LAST_W:0]      w_next;
    logic                 w_finish;

    skf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // gain = floor(E * 2^16 / (E + M)); the quotient never exceeds 2^16, so the
    // division starts from E >> 1 and only the last 17 dividend bits are shifted in
    assign w_sum = {1'b0, r_err} + {1'b0, w_cfg.meas_err};

    skf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_rem_init ({3'b000, r_err[ERR_W-1:1]}),
        .i_bits     ({r_err[0], 16'd0}),
        .i_divisor  (w_sum),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    skf_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_accept    = s_tvalid && s_tready;
    assign w_div_start = w_accept;

    // sample as Q17.16, against the previous estimate
    assign w_target   = {{2{s_tdata[SAMPLE_W-1]}}, s_tdata[SAMPLE_W-1:0], 16'd0};
    assign w_diff     = w_target - {r_last[LAST_W-1], r_last};
    assign w_diff_neg = -w_diff;

    // step = round(|diff| * gain / 2^16), half away from zero on the magnitude
    assign w_step_sum  = {1'b0, w_prod} + HALF_Q16;
    assign w_acc_total = r_acc + {1'b0, w_prod};
    assign w_err_next  = (w_acc_total[ACC_W-1:48] != 4'd0) ? {ERR_W{1'b1}}
                                                          : w_acc_total[47:16];
    assign w_next      = r_neg ? ({r_last[LAST_W-1], r_last} - {1'b0, r_step})
                               : ({r_last[LAST_W-1], r_last} + {1'b0, r_step});
    assign w_finish    = (r_state == S_FIN) && (!r_m_tvalid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: pick the multiplier operands for each step
    always_comb begin
        n_state  = r_state;
        s_tready = 1'b0;
        w_mul_en = 1'b0;
        w_mul_a  = r_mag;
        w_mul_b  = r_gain;
        case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) n_state = S_MUL_STEP;
            end
            S_MUL_STEP: begin
                w_mul_en = 1'b1;
                n_state  = S_MUL_ERR;
            end
            S_MUL_ERR: begin
                w_mul_en = 1'b1;
                w_mul_a  = {2'b00, r_err};
                w_mul_b  = GAIN_ONE - r_gain;
                n_state  = S_MUL_NOISE;
            end
            S_MUL_NOISE: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_step;
                w_mul_b  = {1'b0, w_cfg.proc_noise};
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (w_finish) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // filter state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_err      <= ERR_RESET;
            r_m_tvalid <= 1'b0;
        end else if (w_finish) begin
            r_last     <= w_next[LAST_W-1:0];
            r_err      <= w_err_next;
            r_m_tvalid <= 1'b1;
        end else begin
            if (m_tready) r_m_tvalid <= 1'b0;
            if (w_cfg.err_load) begin
                r_err <= w_cfg.err_load_value;
            end
        end
    end

    // working registers of the current word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg      <= w_diff[LAST_W];
            r_mag      <= w_diff[LAST_W] ? w_diff_neg[LAST_W-1:0] : w_diff[LAST_W-1:0];
            r_sum_zero <= (w_sum == '0);
        end
        if ((r_state == S_DIV) && w_div_done) begin
            // both errors zero: hold the estimate, gain zero
            r_gain <= r_sum_zero ? '0 : w_quot;
        end
        if (r_state == S_MUL_ERR) begin
            r_step <= w_step_sum[49:16];
        end
        if (r_state == S_MUL_NOISE) begin
            r_acc <= {1'b0, w_prod} + HALF_Q16;
        end
        if (w_finish) begin
            r_est_out  <= w_next[EST_W-1:0];
            r_gain_out <= r_gain;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {6'd0, r_gain_out, r_est_out};

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in flight");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[49:33] <= GAIN_ONE))
        else $error("gain above one");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> !w_div_done)
        else $error("divider finished outside its step");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the final step");

endmodule

// File: sim/scalar_kalman_smoother_unit_tb.sv
// Self-checking bench for the scalar Kalman smoother: stream samples in, check estimate and gain.
`timescale 1ns / 100ps

module scalar_kalman_smoother_unit_tb;
    import skf_pkg::*;

    localparam int unsigned PHASES      = 10;   // random register settings
    localparam int unsigned PHASE_WORDS = 154;  // samples per random setting
    localparam int unsigned IDLE_PCT    = 27;   // chance of a bubble per cycle, each side
    localparam int unsigned DRAIN_CYCLES = 30;  // a bit more than one word's latency

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 17'sh0FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 17'sh10000;
    // Register slot 3 decodes to nothing; writes there must be dropped.
    localparam logic [ADDR_W-1:0] ADDR_SPARE = 4'd12;

    typedef struct {
        logic [EST_W-1:0]  est;
        logic [GAIN_W-1:0] gain;
    } t_kalman_out;

    // Tracks the filter state, predicts every result and checks what comes out.
    class t_estimate_tracker;
        longint unsigned meas_err;
        longint unsigned err_level;
        longint unsigned noise;
        longint          est_level;
        t_kalman_out     expected_outs[$];
        int              errors;
        int              samples;
        int              matched;
        int              unity_gains;
        int              zero_gains;
        int              saturations;

        function new();
            meas_err  = ERR_RESET;
            err_level = ERR_RESET;
            noise     = NOISE_RESET;
            est_level = 0;
        endfunction

        function int pending();
            return expected_outs.size();
        endfunction

        function void write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
            case (addr[ADDR_W-1:2])
                REG_MEAS_ERR: meas_err = data;
                REG_INIT_ERR: err_level = data;   // also reloads the error state
                REG_PROC_NOISE: noise = data[NOISE_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the filter by one sample and queue the result it must produce.
        function void note_sample(logic signed [SAMPLE_W-1:0] smp);
            longint          target;
            longint          diff;
            longint          next_est;
            longint unsigned sum;
            longint unsigned gain;
            longint unsigned mag;
            longint unsigned step;
            longint unsigned acc;
            t_kalman_out     res;
            target = longint'(smp) * 65536;
            sum    = err_level + meas_err;
            gain   = (sum == 0) ? 0 : ((err_level << 16) / sum);
            diff   = target - est_level;
            mag    = (diff < 0) ? longint'(-diff) : diff;
            // magnitude of the correction, rounded half away from zero
            step   = (mag * gain + HALF_Q16) >> 16;
            next_est = (diff < 0) ? est_level - longint'(step) : est_level + longint'(step);
            acc = ((longint'(GAIN_ONE) - gain) * err_level + noise * step + HALF_Q16) >> 16;
            if (acc > 64'hFFFF_FFFF) begin
                acc = 64'hFFFF_FFFF;
                saturations++;
            end
            err_level = acc;
            est_level = next_est;
            if (gain == GAIN_ONE) unity_gains++;
            if (gain == 0) zero_gains++;
            res.est  = next_est[EST_W-1:0];
            res.gain = gain[GAIN_W-1:0];
            expected_outs.push_back(res);
            samples++;
        endfunction

        function void check_result(logic [55:0] word);
            t_kalman_out       want;
            logic [EST_W-1:0]  got_est;
            logic [GAIN_W-1:0] got_gain;
            bit                ok;
            got_est  = word[EST_W-1:0];
            got_gain = word[EST_W+GAIN_W-1:EST_W];
            if (expected_outs.size() == 0) begin
                $error("unexpected result word: estimate %0d gain %0d",
                       $signed(got_est), got_gain);
                errors++;
                return;
            end
            want = expected_outs.pop_front();
            ok   = 1'b1;
            if (got_est !== want.est) begin
                $error("estimate mismatch: expected %0d, got %0d",
                       $signed(want.est), $signed(got_est));
                ok = 1'b0;
            end
            if (got_gain !== want.gain) begin
                $error("gain mismatch: expected %0d, got %0d", want.gain, got_gain);
                ok = 1'b0;
            end
            if (ok) matched++;
            else errors++;
        endfunction
    endclass

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata  = '0;   // [16:0] measurement, [23:17] zero
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;         // [32:0] estimate, [49:33] gain, [55:50] zero
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    bit                steady   = 1'b0;  // suppress bubbles on both sides
    int                settings = 0;
    t_estimate_tracker tracker;

    scalar_kalman_smoother_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 i_clk = ~i_clk;

    // Output side: check every taken word, then pick next cycle's ready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) tracker.check_result(m_tdata);
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [ADDR_W-1:0] reg_addr(t_reg_addr r);
        return {r, 2'b00};
    endfunction

    // Setup then access; leave the bus selected so a following write can chain
    // straight into its setup phase.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_reg(addr, data);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(input logic [31:0] meas, input bit load_init,
                                input logic [31:0] init, input logic [31:0] noise_word);
        apb_write(reg_addr(REG_MEAS_ERR), meas);
        if (load_init) apb_write(reg_addr(REG_INIT_ERR), init);
        apb_write(reg_addr(REG_PROC_NOISE), noise_word);
        apb_release();
        settings++;
    endtask

    // Insert random bubbles, then hold the word until the block takes it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, smp};
        do @(posedge i_clk); while (!s_tready);
        tracker.note_sample(smp);
    endtask

    // Hold the input until every outstanding word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly small errors in Q16.16, with zero, one LSB, the top value and full-range random values mixed in.
    function automatic logic [31:0] pick_error();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'hFFFF_FFFF;
        if (r == 2) return 32'd1;
        if (r == 3) return $urandom;
        return $urandom_range(32'h0010_0000, 32'h0000_1000);
    endfunction

    // Noise word: low 16 bits matter, upper bits are random junk the block drops.
    function automatic logic [31:0] pick_noise();
        logic [31:0]  w;
        int unsigned  r;
        w = $urandom;
        r = $urandom_range(5);
        if (r == 0) w[15:0] = 16'd0;
        else if (r == 1) w[15:0] = 16'hFFFF;
        else if (r != 2) w[15:0] = 16'($urandom_range(2000));
        return w;
    endfunction

    // Blend of full-range jumps, slow drift, held values, the rails, zero and minus one.
    function automatic logic signed [SAMPLE_W-1:0] next_sample(
            input logic signed [SAMPLE_W-1:0] prev);
        int unsigned r;
        r = $urandom_range(9);
        if (r < 4) return SAMPLE_W'($urandom);
        if (r < 8) return prev + SAMPLE_W'($urandom_range(512)) - 17'sd256;
        if (r == 8) begin
            case ($urandom_range(3))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return 17'sd0;
                default: return -17'sd1;
            endcase
        end
        return prev;
    endfunction

    initial begin
        logic signed [SAMPLE_W-1:0] smp;
        int unsigned                steady_phase;
        tracker = new();
        steady_phase = $urandom_range(PHASES - 1);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: rails, zero and the smallest steps either way.
        send_sample(17'sd0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(17'sd1);
        send_sample(-17'sd1);
        send_sample(17'sd12345);
        drain();

        // A write to the unmapped slot must leave every register alone.
        apb_write(ADDR_SPARE, 32'hDEAD_BEEF);
        apb_release();
        send_sample(-17'sd300);
        send_sample(17'sd300);
        drain();

        // Zero measurement error: gain of one, estimate snaps to the sample.
        program_regs(32'd0, 1'b1, 32'h0005_0000, 32'd655);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        drain();

        // Both errors zero: gain stays zero and the estimate holds.
        program_regs(32'd0, 1'b1, 32'd0, 32'd655);
        send_sample(17'sd100);
        send_sample(-17'sd100);
        drain();

        // Large errors, full noise and rail-to-rail swings: error saturates.
        program_regs(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'h0000_FFFF);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        drain();

        // Zero error level against the smallest measurement error.
        program_regs(32'd1, 1'b1, 32'd0, 32'd0);
        send_sample(17'sd500);
        drain();

        // Random settings, one of them with no bubbles on either side.
        smp = '0;
        for (int unsigned p = 0; p < PHASES; p++) begin
            program_regs(pick_error(), ($urandom_range(3) != 0), pick_error(), pick_noise());
            steady = (p == steady_phase);
            for (int unsigned k = 0; k < PHASE_WORDS; k++) begin
                smp = next_sample(smp);
                send_sample(smp);
                if ($urandom_range(99) < 2) drain();
            end
            drain();
            steady = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d samples through %0d register settings; %0d results matched.",
                 tracker.samples, settings, tracker.matched);
        $display("Gain of one %0d times, zero gain %0d times, error saturated %0d times.",
                 tracker.unity_gains, tracker.zero_gains, tracker.saturations);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/core/skf_pkg.sv
rtl/core/skf_regs.sv
rtl/core/skf_div.sv
rtl/core/skf_mul.sv
rtl/core/scalar_kalman_smoother_unit.sv
sim/scalar_kalman_smoother_unit_tb.sv
